[hdl/assert_macros.svh]
// Assertion macros for the chmod spec applier RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/chmod_pkg.sv]
// Types and constants for the chmod spec applier.
// No dependencies; used by chmod_spec_applier_core.
`default_nettype none

package chmod_pkg;

    localparam int MAX_CLAUSE_CHARS_DEF = 255;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [8:0] MODE_MASK = 9'o777;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_WHO,
        PH_GAP,
        PH_PERMS,
        PH_BAD
    } phase_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_SET
    } op_t;

    typedef struct packed {
        logic [7:0] length;
        logic       oct_cand;
        logic       oct_seen;
        logic [8:0] oct_val;
        logic [2:0] oct_cnt;
        logic       oct_stop;
        phase_t     phase;
        logic [2:0] who_bits;
        logic [2:0] who_cnt;
        op_t        op;
        logic [2:0] perm;
    } clause_t;

    localparam clause_t CLAUSE_CLEAR = '{
        length:   8'd0,
        oct_cand: 1'b1,
        oct_seen: 1'b0,
        oct_val:  9'd0,
        oct_cnt:  3'd0,
        oct_stop: 1'b0,
        phase:    PH_LEAD,
        who_bits: 3'd0,
        who_cnt:  3'd0,
        op:       OP_ADD,
        perm:     3'd0
    };

    localparam int OCT_MAX_DIGITS = 5;

endpackage

`default_nettype wire

[hdl/chmod_spec_applier_core.sv]
// Chmod spec applier: parses a chmod-style spec one character per word.
// Depends on chmod_pkg and assert_macros.svh.
// The last input word waits in the input register; when the parser takes it, the result
// word is registered; a stalled output holds it. Throughput: one word per cycle unless a
// result is stalled, set by the single input register feeding the parser state update.
// Reset: asynchronous active low; clears the mode, the clause state and both valid flags.
`default_nettype none
`include "assert_macros.svh"

module chmod_spec_applier_core #(
    parameter int MAX_CLAUSE_CHARS = chmod_pkg::MAX_CLAUSE_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] ch, [16:8] start_mode, rest zero
    input  wire logic        s_axis_tlast,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata    // [8:0] result_mode, rest zero
);

    localparam logic [7:0] MaxLen = 8'(MAX_CLAUSE_CHARS);

    logic                in_valid_reg;
    logic [7:0]          in_ch_reg;
    logic [8:0]          in_sm_reg;
    logic                in_last_reg;
    logic                at_start_reg;
    logic                at_start_next;
    logic [8:0]          mode_reg;
    logic [8:0]          mode_next;
    chmod_pkg::clause_t  clause_reg;
    chmod_pkg::clause_t  clause_next;
    logic                out_valid_reg;
    logic [8:0]          out_mode_reg;
    logic                advance;
    logic [8:0]          mode_base;
    logic [8:0]          mode_fed;
    chmod_pkg::clause_t  clause_base;
    chmod_pkg::clause_t  clause_fed;

    function automatic chmod_pkg::clause_t feed(chmod_pkg::clause_t c, logic [7:0] ch);
        chmod_pkg::clause_t n;
        logic               blank;
        logic               digit;
        logic               who;
        logic               is_op;
        chmod_pkg::op_t     oc;
        n     = c;
        blank = (ch == chmod_pkg::CH_SPACE) || (ch == chmod_pkg::CH_TAB);
        digit = (ch >= chmod_pkg::CH_ZERO) && (ch <= chmod_pkg::CH_SEVEN);
        who   = ch inside {chmod_pkg::CH_U, chmod_pkg::CH_G, chmod_pkg::CH_O, chmod_pkg::CH_A};
        is_op = ch inside {chmod_pkg::CH_PLUS, chmod_pkg::CH_MINUS, chmod_pkg::CH_EQUAL};
        if (ch == chmod_pkg::CH_MINUS)
        begin
            oc = chmod_pkg::OP_SUB;
        end
        else if (ch == chmod_pkg::CH_EQUAL)
        begin
            oc = chmod_pkg::OP_SET;
        end
        else
        begin
            oc = chmod_pkg::OP_ADD;
        end
        if (c.length < MaxLen)
        begin
            n.length = c.length + 8'd1;
            if (!blank && !digit)
            begin
                n.oct_cand = 1'b0;
            end
            if (digit)
            begin
                n.oct_seen = 1'b1;
                if (!c.oct_stop && (c.oct_cnt < 3'(chmod_pkg::OCT_MAX_DIGITS)))
                begin
                    n.oct_val = {c.oct_val[5:0], ch[2:0]};
                    n.oct_cnt = c.oct_cnt + 3'd1;
                    if (n.oct_cnt >= 3'(chmod_pkg::OCT_MAX_DIGITS))
                    begin
                        n.oct_stop = 1'b1;
                    end
                end
            end
            else if (blank && c.oct_seen)
            begin
                n.oct_stop = 1'b1;
            end
            case (c.phase)
                chmod_pkg::PH_LEAD, chmod_pkg::PH_WHO:
                begin
                    if (who)
                    begin
                        if (c.who_cnt < 3'd7)
                        begin
                            n.who_cnt = c.who_cnt + 3'd1;
                            case (ch)
                                chmod_pkg::CH_U: n.who_bits = c.who_bits | 3'b100;
                                chmod_pkg::CH_G: n.who_bits = c.who_bits | 3'b010;
                                chmod_pkg::CH_O: n.who_bits = c.who_bits | 3'b001;
                                default:         n.who_bits = 3'b111;
                            endcase
                        end
                        n.phase = chmod_pkg::PH_WHO;
                    end
                    else if (blank)
                    begin
                        if (c.phase == chmod_pkg::PH_WHO)
                        begin
                            n.phase = chmod_pkg::PH_GAP;
                        end
                    end
                    else if (is_op)
                    begin
                        n.op    = oc;
                        n.phase = chmod_pkg::PH_PERMS;
                    end
                    else
                    begin
                        n.phase = chmod_pkg::PH_BAD;
                    end
                end
                chmod_pkg::PH_GAP:
                begin
                    if (is_op)
                    begin
                        n.op    = oc;
                        n.phase = chmod_pkg::PH_PERMS;
                    end
                    else if (!blank)
                    begin
                        n.phase = chmod_pkg::PH_BAD;
                    end
                end
                chmod_pkg::PH_PERMS:
                begin
                    case (ch)
                        chmod_pkg::CH_R: n.perm = c.perm | 3'b100;
                        chmod_pkg::CH_W: n.perm = c.perm | 3'b010;
                        chmod_pkg::CH_X: n.perm = c.perm | 3'b001;
                        default:         n.perm = c.perm;
                    endcase
                end
                default:
                begin
                    n.phase = c.phase;
                end
            endcase
        end
        return n;
    endfunction

    function automatic logic [8:0] finish(chmod_pkg::clause_t c, logic [8:0] mode);
        logic [8:0] wm;
        logic [8:0] pm;
        logic [8:0] mp;
        logic [8:0] res;
        wm  = (c.who_cnt == 3'd0) ? chmod_pkg::MODE_MASK : 9'd0;
        wm  = wm | {{3{c.who_bits[2]}}, {3{c.who_bits[1]}}, {3{c.who_bits[0]}}};
        pm  = {3{c.perm}};
        mp  = pm & wm;
        res = mode;
        if (c.phase == chmod_pkg::PH_LEAD)
        begin
            res = mode;
        end
        else if (c.oct_cand)
        begin
            res = c.oct_val;
        end
        else if (c.phase == chmod_pkg::PH_PERMS)
        begin
            case (c.op)
                chmod_pkg::OP_SET: res = (mode & ~wm) | mp;
                chmod_pkg::OP_ADD: res = mode | mp;
                default:           res = mode & ~mp;
            endcase
        end
        return res;
    endfunction

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_mode_reg};

    always_comb
    begin
        mode_base   = at_start_reg ? in_sm_reg : mode_reg;
        clause_base = at_start_reg ? chmod_pkg::CLAUSE_CLEAR : clause_reg;
        if (in_ch_reg == chmod_pkg::CH_COMMA)
        begin
            mode_fed   = finish(clause_base, mode_base);
            clause_fed = chmod_pkg::CLAUSE_CLEAR;
        end
        else
        begin
            mode_fed   = mode_base;
            clause_fed = feed(clause_base, in_ch_reg);
        end
        if (in_last_reg)
        begin
            mode_next     = finish(clause_fed, mode_fed);
            clause_next   = chmod_pkg::CLAUSE_CLEAR;
            at_start_next = 1'b1;
        end
        else
        begin
            mode_next     = mode_fed;
            clause_next   = clause_fed;
            at_start_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            at_start_reg  <= 1'b1;
            mode_reg      <= 9'd0;
            clause_reg    <= chmod_pkg::CLAUSE_CLEAR;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (in_valid_reg && advance)
            begin
                mode_reg     <= mode_next;
                clause_reg   <= clause_next;
                at_start_reg <= at_start_next;
                if (in_last_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ch_reg   <= s_axis_tdata[7:0];
            in_sm_reg   <= s_axis_tdata[16:8];
            in_last_reg <= s_axis_tlast;
        end
        if (in_valid_reg && advance && in_last_reg)
        begin
            out_mode_reg <= mode_next;
        end
    end

    `ASSERT_NEXT(a_last_restarts, clk, rst_n, in_valid_reg && advance && in_last_reg, at_start_reg)
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_valid_reg && advance && in_last_reg, m_axis_tvalid)
    `ASSERT_SAME(a_result_from_last, clk, rst_n, $rose(m_axis_tvalid), $past(in_valid_reg && in_last_reg))
    `ASSERT_SAME(a_clause_bound, clk, rst_n, 1'b1, clause_reg.length <= MaxLen)

endmodule

`default_nettype wire

[tb/sv/chmod_spec_applier_core_tb.sv]
// Testbench for chmod_spec_applier_core: streams chmod-style specs one character per word
// and checks each final mode against a mode predictor kept in step with the accepted words.
// Depends on chmod_pkg and the core RTL.
`timescale 1ns / 100ps

module chmod_spec_applier_core_tb;

    localparam int WORD_TARGET = 1650;
    localparam int CYCLE_LIMIT = 1000000;

    class chmod_mode_predictor;
        logic [8:0]        mode;
        bit                spec_start;
        int                clen;
        bit                oct_cand;
        bit                oct_seen;
        bit                oct_stop;
        logic [8:0]        oct_val;
        int                oct_cnt;
        chmod_pkg::phase_t phase;
        logic [2:0]        who_mask;
        int                who_cnt;
        chmod_pkg::op_t    op;
        logic [2:0]        perms;
        logic [8:0]        expected_modes[$];
        int                errors;

        function new();
            mode = '0;
            spec_start = 1'b1;
            errors = 0;
            clear_clause();
        endfunction

        function void clear_clause();
            clen = 0;
            oct_cand = 1'b1;
            oct_seen = 1'b0;
            oct_stop = 1'b0;
            oct_val = '0;
            oct_cnt = 0;
            phase = chmod_pkg::PH_LEAD;
            who_mask = '0;
            who_cnt = 0;
            op = chmod_pkg::OP_ADD;
            perms = '0;
        endfunction

        function void feed(logic [7:0] c);
            bit             blank;
            bit             digit;
            bit             who_ch;
            bit             is_op;
            chmod_pkg::op_t oc;
            blank = (c == chmod_pkg::CH_SPACE) || (c == chmod_pkg::CH_TAB);
            digit = (c >= chmod_pkg::CH_ZERO) && (c <= chmod_pkg::CH_SEVEN);
            who_ch = (c == chmod_pkg::CH_U) || (c == chmod_pkg::CH_G) ||
                     (c == chmod_pkg::CH_O) || (c == chmod_pkg::CH_A);
            is_op = 1'b1;
            oc = chmod_pkg::OP_ADD;
            case (c)
                chmod_pkg::CH_PLUS:  oc = chmod_pkg::OP_ADD;
                chmod_pkg::CH_MINUS: oc = chmod_pkg::OP_SUB;
                chmod_pkg::CH_EQUAL: oc = chmod_pkg::OP_SET;
                default:             is_op = 1'b0;
            endcase
            if (clen >= chmod_pkg::MAX_CLAUSE_CHARS_DEF)
                return;
            clen++;

            if (!blank && !digit)
                oct_cand = 1'b0;
            if (digit)
            begin
                oct_seen = 1'b1;
                if (!oct_stop && oct_cnt < chmod_pkg::OCT_MAX_DIGITS)
                begin
                    oct_val = {oct_val[5:0], c[2:0]};
                    oct_cnt++;
                    if (oct_cnt >= chmod_pkg::OCT_MAX_DIGITS)
                        oct_stop = 1'b1;
                end
            end
            else if (blank && oct_seen)
                oct_stop = 1'b1;

            case (phase)
                chmod_pkg::PH_LEAD, chmod_pkg::PH_WHO:
                begin
                    if (who_ch)
                    begin
                        if (who_cnt < 7)
                        begin
                            who_cnt++;
                            case (c)
                                chmod_pkg::CH_U: who_mask |= 3'b100;
                                chmod_pkg::CH_G: who_mask |= 3'b010;
                                chmod_pkg::CH_O: who_mask |= 3'b001;
                                default:         who_mask = 3'b111;
                            endcase
                        end
                        phase = chmod_pkg::PH_WHO;
                    end
                    else if (blank)
                    begin
                        if (phase == chmod_pkg::PH_WHO)
                            phase = chmod_pkg::PH_GAP;
                    end
                    else if (is_op)
                    begin
                        op = oc;
                        phase = chmod_pkg::PH_PERMS;
                    end
                    else
                        phase = chmod_pkg::PH_BAD;
                end
                chmod_pkg::PH_GAP:
                begin
                    if (is_op)
                    begin
                        op = oc;
                        phase = chmod_pkg::PH_PERMS;
                    end
                    else if (!blank)
                        phase = chmod_pkg::PH_BAD;
                end
                chmod_pkg::PH_PERMS:
                begin
                    if (c == chmod_pkg::CH_R)
                        perms |= 3'b100;
                    else if (c == chmod_pkg::CH_W)
                        perms |= 3'b010;
                    else if (c == chmod_pkg::CH_X)
                        perms |= 3'b001;
                end
                default:;
            endcase
        endfunction

        function void close_clause();
            logic [8:0] wm;
            logic [8:0] granted;
            if (phase == chmod_pkg::PH_LEAD)
                ;
            else if (oct_cand)
                mode = oct_val;
            else if (phase == chmod_pkg::PH_PERMS)
            begin
                wm = (who_cnt == 0) ? chmod_pkg::MODE_MASK : 9'o000;
                if (who_mask[2])
                    wm |= 9'o700;
                if (who_mask[1])
                    wm |= 9'o070;
                if (who_mask[0])
                    wm |= 9'o007;
                granted = {3{perms}} & wm;
                case (op)
                    chmod_pkg::OP_SET: mode = (mode & ~wm) | granted;
                    chmod_pkg::OP_ADD: mode = mode | granted;
                    default:           mode = mode & ~granted;
                endcase
            end
            clear_clause();
        endfunction

        function void note_word(logic [7:0] c, logic [8:0] start, logic lst);
            if (spec_start)
            begin
                mode = start;
                spec_start = 1'b0;
                clear_clause();
            end
            if (c == chmod_pkg::CH_COMMA)
                close_clause();
            else
                feed(c);
            if (lst)
            begin
                close_clause();
                expected_modes.push_back(mode);
                spec_start = 1'b1;
            end
        endfunction

        function void check_mode(logic [8:0] got);
            logic [8:0] want;
            if (expected_modes.size() == 0)
            begin
                $error("result_mode: expected none, got %0o", got);
                errors++;
                return;
            end
            want = expected_modes.pop_front();
            if (got !== want)
            begin
                $error("result_mode: expected %0o, got %0o", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] ch, [16:8] start_mode, rest zero
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [8:0] result_mode, rest zero

    chmod_mode_predictor modes = new();
    logic [7:0]          spec_chars[$];
    bit                  tx_steady;
    int                  words_sent = 0;
    int                  cycles = 0;

    chmod_spec_applier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                modes.note_word(s_axis_tdata[7:0], s_axis_tdata[16:8], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                modes.check_mode(m_axis_tdata[8:0]);
        end
    end

    function automatic int idle_len(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick(string choices);
        return choices[$urandom_range(0, choices.len() - 1)];
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == chmod_pkg::CH_COMMA) ? chmod_pkg::CH_X : c;
    endfunction

    function automatic void add_clause();
        int kind;
        int n;
        int r;
        int base;
        int span;
        kind = $urandom_range(0, 99);
        base = spec_chars.size();
        if (kind < 30)
        begin
            repeat ($urandom_range(0, 2)) spec_chars.push_back(pick(" \t"));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 3);
            repeat (n) spec_chars.push_back(pick("ugoa"));
            repeat ($urandom_range(0, 1)) spec_chars.push_back(pick(" \t"));
            spec_chars.push_back(pick("+-="));
            repeat ($urandom_range(0, 5))
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    spec_chars.push_back(pick("rwx"));
                else if (r < 8)
                    spec_chars.push_back(pick("+-=ugo"));
                else if (r < 9)
                    spec_chars.push_back(pick(" \t"));
                else
                    spec_chars.push_back(any_char());
            end
        end
        else if (kind < 60)
        begin
            repeat ($urandom_range(0, 1)) spec_chars.push_back(pick(" \t"));
            repeat ($urandom_range(1, 7)) spec_chars.push_back(pick("01234567"));
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 2)) spec_chars.push_back(pick(" \t"));
                repeat ($urandom_range(1, 3)) spec_chars.push_back(pick("01234567"));
            end
            repeat ($urandom_range(0, 1)) spec_chars.push_back(pick(" \t"));
        end
        else if (kind < 70)
        begin
            repeat ($urandom_range(1, 3)) spec_chars.push_back(pick("ugoa"));
            repeat ($urandom_range(0, 1)) spec_chars.push_back(pick(" \t"));
            spec_chars.push_back(pick("rwx9zq"));
            spec_chars.push_back(pick("+-="));
            repeat ($urandom_range(0, 3)) spec_chars.push_back(pick("rwx"));
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(0, 3)) spec_chars.push_back(pick("ugoa"));
            repeat ($urandom_range(1, 3)) spec_chars.push_back(pick("rwx"));
        end
        else if (kind < 88)
        begin
            repeat ($urandom_range(0, 3)) spec_chars.push_back(pick("01234567"));
            spec_chars.push_back(pick("89ux+"));
            repeat ($urandom_range(0, 2)) spec_chars.push_back(pick("01234567"));
        end
        else if (kind < 94)
        begin
            repeat ($urandom_range(1, 6)) spec_chars.push_back(any_char());
        end
        else if (kind < 99)
        begin
            repeat ($urandom_range(0, 3)) spec_chars.push_back(pick(" \t"));
        end
        else
        begin
            // straddle the clause length cap with the meaningful tail
            span = $urandom_range(250, 300);
            if ($urandom_range(0, 1) == 0)
            begin
                spec_chars.push_back(pick("ugoa"));
                spec_chars.push_back(pick("+-="));
                while (spec_chars.size() - base < span - 4)
                    spec_chars.push_back(pick(" \tq"));
                repeat (4) spec_chars.push_back(pick("rwx"));
            end
            else
            begin
                while (spec_chars.size() - base < span - 3)
                    spec_chars.push_back(pick(" \t"));
                repeat (3) spec_chars.push_back(pick("01234567"));
            end
        end
    endfunction

    function automatic void build_spec();
        int n;
        spec_chars.delete();
        if ($urandom_range(0, 19) == 0)
            spec_chars.push_back(chmod_pkg::CH_COMMA);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                spec_chars.push_back(chmod_pkg::CH_COMMA);
            add_clause();
        end
        if ($urandom_range(0, 9) == 0)
            spec_chars.push_back(chmod_pkg::CH_COMMA);
        if (spec_chars.size() == 0)
            spec_chars.push_back(pick(" \t,"));
    endfunction

    task automatic push_char(input logic [7:0] c, input logic [8:0] start, input logic lst);
        int gap;
        gap = idle_len(tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, start, c};
        s_axis_tlast <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_spec(input logic [8:0] start);
        logic [8:0] sm;
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < spec_chars.size(); i++)
        begin
            sm = (i == 0) ? start : 9'($urandom_range(0, 511));
            push_char(spec_chars[i], sm, i == spec_chars.size() - 1);
        end
    endtask

    task automatic send_text(input string txt, input logic [8:0] start);
        spec_chars.delete();
        for (int i = 0; i < txt.len(); i++)
            spec_chars.push_back(txt[i]);
        send_spec(start);
    endtask

    initial
    begin
        int run;
        forever
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(50, 200)) @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 8)) @(posedge clk);
                run = idle_len(1'b0);
                if (run > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        send_text("755", 9'o000);
        send_text("u+x", 9'o600);
        send_text("go-w", 9'o777);
        send_text("a=r", 9'o777);
        send_text("+rwx", 9'o000);
        send_text(" ", 9'o123);
        send_text(",", 9'o777);
        send_text("u\377x", 9'o555);
        send_text("\001", 9'o777);

        while (words_sent < WORD_TARGET)
        begin
            build_spec();
            send_spec(9'($urandom_range(0, 511)));
        end
        s_axis_tvalid <= 1'b0;

        while (modes.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (modes.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
